FILE: src/gkc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gkc_pkg
// Shared types and constants for the k-core peeling block.
// ----------------------------------------------------------------------------
package gkc_pkg;

    // Width of node numbers, degrees and configuration values.
    localparam int NODE_W = 7;
    localparam int DEG_W  = 7;
    localparam int CFG_W  = 7;

    // Largest degree a counter can hold.
    localparam logic [DEG_W-1:0] DEG_MAX = 7'd127;

    // Commands carried by a request transfer.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_MIN_DEGREE = 1'b1;

    // Request payload: one edge load or one run command.
    typedef struct packed {
        logic              cmd;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } req_t;

    // Response payload: the size of the surviving core.
    typedef struct packed {
        logic [NODE_W-1:0] core_size;
        logic              core_nonempty;
    } rsp_t;

    // Write strobes for the two stores.
    typedef struct packed {
        logic adj_we;
        logic deg_we;
    } store_ctl_t;

endpackage

FILE: src/graph_k_core_size.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_k_core_size
// K-core peeling of a small undirected graph held in an adjacency memory.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on req_valid/req_ready/req_data. A load command stores one
// undirected edge; a run command peels the graph and produces one response
// transfer on rsp_valid/rsp_ready/rsp_data with the core size.
// The block takes one request at a time. A load keeps it busy after its
// transfer while it reads and writes each endpoint's row and degree (states
// LD_RDA, LD_WRA, LD_RDB, LD_WRB). A run reads and checks each node's degree
// in every sweep; each removed node adds a walk over all MAX_NODES entries of
// its adjacency row that decrements the degree of each live neighbor. After
// the last sweep the response register is loaded once it is free, then a
// clearing pass empties the stores before the next request is taken.
// After reset the same clearing pass runs and req_ready stays low until it
// ends. Configuration writes are taken at any time.
// The response sits in an output register: while the receiver stalls, new
// loads are still accepted; a second run result waits until the first one
// has been transferred.
// ----------------------------------------------------------------------------
module graph_k_core_size #(
    parameter int MAX_NODES = 64
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          req_valid,
    output logic                         req_ready,
    input  gkc_pkg::req_t                req_data,
    output logic                         rsp_valid,
    input  wire                          rsp_ready,
    output gkc_pkg::rsp_t                rsp_data,
    input  wire                          cfg_we,
    input  wire                          cfg_index,
    input  wire  [gkc_pkg::CFG_W-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);
    localparam logic [gkc_pkg::NODE_W-1:0] MAX_N = gkc_pkg::NODE_W'(MAX_NODES);

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b0000_0000_0001,
        ST_IDLE   = 12'b0000_0000_0010,
        ST_LD_RDA = 12'b0000_0000_0100,
        ST_LD_WRA = 12'b0000_0000_1000,
        ST_LD_RDB = 12'b0000_0001_0000,
        ST_LD_WRB = 12'b0000_0010_0000,
        ST_SW_RD  = 12'b0000_0100_0000,
        ST_SW_CHK = 12'b0000_1000_0000,
        ST_RM_ROW = 12'b0001_0000_0000,
        ST_DEC_RD = 12'b0010_0000_0000,
        ST_DEC_WR = 12'b0100_0000_0000,
        ST_DONE   = 12'b1000_0000_0000
    } state_t;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               a_reg, a_next;
    logic [IDX_W-1:0]               b_reg, b_next;
    logic [IDX_W-1:0]               i_reg, i_next;
    logic [IDX_W-1:0]               j_reg, j_next;
    logic [MAX_NODES-1:0]           row_reg, row_next;
    logic [MAX_NODES-1:0]           alive_reg, alive_next;
    logic [gkc_pkg::NODE_W-1:0]     live_reg, live_next;
    logic                           changed_reg, changed_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    gkc_pkg::rsp_t                  rsp_data_reg, rsp_data_next;
    logic [gkc_pkg::CFG_W-1:0]      node_count_reg;
    logic [gkc_pkg::CFG_W-1:0]      min_degree_reg;

    gkc_pkg::store_ctl_t            st_ctl;
    logic [IDX_W-1:0]               st_waddr;
    logic [MAX_NODES-1:0]           st_wrow;
    logic [gkc_pkg::DEG_W-1:0]      st_wdeg;
    logic [IDX_W-1:0]               st_raddr;
    logic [MAX_NODES-1:0]           st_rrow;
    logic [gkc_pkg::DEG_W-1:0]      st_rdeg;

    logic [gkc_pkg::NODE_W-1:0]     n_eff;
    logic [gkc_pkg::NODE_W-1:0]     a_m1;
    logic [gkc_pkg::NODE_W-1:0]     b_m1;
    logic                           edge_ok;
    logic                           req_xfer;
    logic                           rsp_xfer;
    logic [MAX_NODES-1:0]           one_hot_base;

    gkc_store #(
        .DEPTH (MAX_NODES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .ctl   (st_ctl),
        .waddr (st_waddr),
        .wrow  (st_wrow),
        .wdeg  (st_wdeg),
        .raddr (st_raddr),
        .rrow  (st_rrow),
        .rdeg  (st_rdeg)
    );

    // Effective node count and edge range check.
    assign n_eff = (node_count_reg > MAX_N) ? MAX_N : node_count_reg;
    assign a_m1 = req_data.node_a - gkc_pkg::NODE_W'(1);
    assign b_m1 = req_data.node_b - gkc_pkg::NODE_W'(1);
    assign edge_ok = (req_data.node_a != '0) && (req_data.node_a <= n_eff) &&
                     (req_data.node_b != '0) && (req_data.node_b <= n_eff);
    assign one_hot_base = MAX_NODES'(1);

    assign req_ready = (state_reg == ST_IDLE);
    assign req_xfer  = req_valid && req_ready;
    assign rsp_xfer  = rsp_valid_reg && rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Sequencer: edge loads, peeling sweeps, neighbor walks and clearing.
    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        row_next       = row_reg;
        alive_next     = alive_reg;
        live_next      = live_reg;
        changed_next   = changed_reg;
        rsp_valid_next = rsp_xfer ? 1'b0 : rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        st_ctl         = '0;
        st_waddr       = '0;
        st_wrow        = '0;
        st_wdeg        = '0;
        st_raddr       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                st_ctl.adj_we = 1'b1;
                st_ctl.deg_we = 1'b1;
                st_waddr      = j_reg;
                alive_next    = '1;
                if (j_reg == LAST_IDX)
                begin
                    j_next     = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req_data.cmd == gkc_pkg::CMD_RUN)
                    begin
                        alive_next   = '1;
                        live_next    = n_eff;
                        changed_next = 1'b0;
                        i_next       = '0;
                        state_next   = (n_eff == '0) ? ST_DONE : ST_SW_RD;
                    end
                    else if (edge_ok)
                    begin
                        a_next     = a_m1[IDX_W-1:0];
                        b_next     = b_m1[IDX_W-1:0];
                        state_next = ST_LD_RDA;
                    end
                end
            end
            ST_LD_RDA:
            begin
                st_raddr   = a_reg;
                state_next = ST_LD_WRA;
            end
            ST_LD_WRA:
            begin
                st_waddr = a_reg;
                st_wrow  = st_rrow | (one_hot_base << b_reg);
                st_wdeg  = (st_rdeg == gkc_pkg::DEG_MAX) ? st_rdeg
                                                         : st_rdeg + gkc_pkg::DEG_W'(1);
                if (!st_rrow[b_reg])
                begin
                    st_ctl.adj_we = 1'b1;
                    st_ctl.deg_we = 1'b1;
                end
                state_next = ST_LD_RDB;
            end
            ST_LD_RDB:
            begin
                st_raddr   = b_reg;
                state_next = ST_LD_WRB;
            end
            ST_LD_WRB:
            begin
                st_waddr = b_reg;
                st_wrow  = st_rrow | (one_hot_base << a_reg);
                st_wdeg  = (st_rdeg == gkc_pkg::DEG_MAX) ? st_rdeg
                                                         : st_rdeg + gkc_pkg::DEG_W'(1);
                if (!st_rrow[a_reg])
                begin
                    st_ctl.adj_we = 1'b1;
                    st_ctl.deg_we = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SW_RD:
            begin
                st_raddr   = i_reg;
                state_next = ST_SW_CHK;
            end
            ST_SW_CHK:
            begin
                if (alive_reg[i_reg] && (st_rdeg < min_degree_reg))
                begin
                    // Remove this node and fetch its row for the neighbor walk.
                    alive_next[i_reg] = 1'b0;
                    st_ctl.deg_we     = 1'b1;
                    st_waddr          = i_reg;
                    st_wdeg           = '0;
                    st_raddr          = i_reg;
                    live_next         = (live_reg != '0) ? live_reg - gkc_pkg::NODE_W'(1)
                                                         : live_reg;
                    changed_next      = 1'b1;
                    state_next        = ST_RM_ROW;
                end
                else if (gkc_pkg::NODE_W'(i_reg) == n_eff - gkc_pkg::NODE_W'(1))
                begin
                    i_next       = '0;
                    changed_next = 1'b0;
                    state_next   = (!changed_reg || live_reg == '0) ? ST_DONE : ST_SW_RD;
                end
                else
                begin
                    i_next     = i_reg + IDX_W'(1);
                    state_next = ST_SW_RD;
                end
            end
            ST_RM_ROW:
            begin
                row_next   = st_rrow;
                j_next     = '0;
                state_next = ST_DEC_RD;
            end
            ST_DEC_RD, ST_DEC_WR:
            begin
                if ((state_reg == ST_DEC_RD) && row_reg[j_reg] && alive_reg[j_reg])
                begin
                    st_raddr   = j_reg;
                    state_next = ST_DEC_WR;
                end
                else
                begin
                    if (state_reg == ST_DEC_WR)
                    begin
                        st_waddr      = j_reg;
                        st_wdeg       = st_rdeg - gkc_pkg::DEG_W'(1);
                        st_ctl.deg_we = (st_rdeg != '0);
                    end
                    if (j_reg != LAST_IDX)
                    begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_DEC_RD;
                    end
                    else
                    begin
                        // Neighbor walk done: move on to the next node.
                        j_next = '0;
                        if (gkc_pkg::NODE_W'(i_reg) == n_eff - gkc_pkg::NODE_W'(1))
                        begin
                            i_next       = '0;
                            changed_next = 1'b0;
                            state_next   = (live_reg == '0) ? ST_DONE : ST_SW_RD;
                        end
                        else
                        begin
                            i_next     = i_reg + IDX_W'(1);
                            state_next = ST_SW_RD;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next              = 1'b1;
                    rsp_data_next.core_size     = live_reg;
                    rsp_data_next.core_nonempty = (live_reg != '0);
                    j_next                      = '0;
                    state_next                  = ST_CLEAR;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                j_next     = '0;
            end
        endcase
    end

    // Control and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            j_reg         <= '0;
            i_reg         <= '0;
            alive_reg     <= '1;
            live_reg      <= '0;
            changed_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            i_reg         <= i_next;
            alive_reg     <= alive_next;
            live_reg      <= live_next;
            changed_reg   <= changed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        row_reg      <= row_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= gkc_pkg::CFG_W'(64);
            min_degree_reg <= gkc_pkg::CFG_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gkc_pkg::CFG_NODE_COUNT: node_count_reg <= cfg_data;
                gkc_pkg::CFG_MIN_DEGREE: min_degree_reg <= cfg_data;
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    // A response only appears after the result was formed.
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the done step");

    // The live count never exceeds the node capacity.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= MAX_N)
        else $error("live count above capacity");

    // Between commands every node is marked live.
    a_alive_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (&alive_reg))
        else $error("alive mask not restored after a run");

    // A stalled response keeps its value.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_ready) |=> $stable(rsp_data_reg))
        else $error("response changed while stalled");
`endif

endmodule
`default_nettype wire

FILE: src/gkc_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gkc_store
// Adjacency row memory and degree memory, one write and one registered read.
// ----------------------------------------------------------------------------
module gkc_store #(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  wire                           clk,
    input  gkc_pkg::store_ctl_t           ctl,
    input  wire  [IDX_W-1:0]              waddr,
    input  wire  [DEPTH-1:0]              wrow,
    input  wire  [gkc_pkg::DEG_W-1:0]     wdeg,
    input  wire  [IDX_W-1:0]              raddr,
    output logic [DEPTH-1:0]              rrow,
    output logic [gkc_pkg::DEG_W-1:0]     rdeg
);

    logic [DEPTH-1:0]          adj_mem [DEPTH];
    logic [gkc_pkg::DEG_W-1:0] deg_mem [DEPTH];

    // Adjacency rows: write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.adj_we)
        begin
            adj_mem[waddr] <= wrow;
        end
        rrow <= adj_mem[raddr];
    end

    // Degree counts: write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (ctl.deg_we)
        begin
            deg_mem[waddr] <= wdeg;
        end
        rdeg <= deg_mem[raddr];
    end

endmodule
`default_nettype wire

FILE: tb/graph_k_core_size_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_k_core_size_tb
// Self-checking bench for the k-core peeling block. Edge loads and run
// commands are driven through the request channel with random idling on both
// sides; every core report is compared with a behavioral peeling model.
// ----------------------------------------------------------------------------
module graph_k_core_size_tb;

    localparam int NODES      = 64;
    localparam int CYCLE_CAP  = 3000000;
    localparam int ROW_COUNT  = 22;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    gkc_pkg::req_t req_data;
    logic rsp_valid;
    logic rsp_ready;
    gkc_pkg::rsp_t rsp_data;
    logic cfg_we;
    logic cfg_index;
    logic [gkc_pkg::CFG_W-1:0] cfg_data;

    // Model of the graph store and registers.
    logic [NODES-1:0] adj_rows [NODES];
    int               degree [NODES];
    logic [6:0]       cfg_nodes;
    logic [6:0]       cfg_min_deg;
    gkc_pkg::rsp_t    core_queue [$];

    int  error_count;
    int  cycle_count;
    int  reports_seen;
    int  loads_sent;
    bit  idle_enabled;

    // Directed stimulus table.
    typedef struct {
        logic [6:0] nodes;
        logic [6:0] min_deg;
        logic       cmd;
        logic [6:0] a;
        logic [6:0] b;
        logic       known;
        logic [6:0] size;
    } step_row_t;

    graph_k_core_size #(.MAX_NODES(NODES)) dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int nodes_used();
        return (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < NODES; i++)
        begin
            adj_rows[i] = '0;
            degree[i]   = 0;
        end
    endfunction

    // Store one undirected edge; out-of-range endpoints are dropped.
    function automatic void store_edge(int a, int b);
        int n;
        n = nodes_used();
        if (a < 1 || a > n || b < 1 || b > n)
            return;
        a--;
        b--;
        if (!adj_rows[a][b])
        begin
            adj_rows[a][b] = 1'b1;
            if (degree[a] < 127)
                degree[a]++;
        end
        if (!adj_rows[b][a])
        begin
            adj_rows[b][a] = 1'b1;
            if (degree[b] < 127)
                degree[b]++;
        end
    endfunction

    // Peel the graph in ascending sweeps and return the surviving count.
    function automatic gkc_pkg::rsp_t peel_core();
        int n;
        int live;
        bit changed;
        logic [NODES-1:0] alive;
        gkc_pkg::rsp_t r;
        n     = nodes_used();
        live  = n;
        alive = '1;
        while (live > 0)
        begin
            changed = 1'b0;
            for (int i = 0; i < n; i++)
            begin
                if (alive[i] && degree[i] < int'(cfg_min_deg))
                begin
                    alive[i]  = 1'b0;
                    degree[i] = 0;
                    live--;
                    for (int j = 0; j < NODES; j++)
                        if (adj_rows[i][j] && alive[j] && degree[j] > 0)
                            degree[j]--;
                    changed = 1'b1;
                end
            end
            if (!changed)
                break;
        end
        r.core_size     = 7'(live);
        r.core_nonempty = (live > 0);
        clear_graph();
        return r;
    endfunction

    // Optional idle burst on the request side; valid also drops in drain.
    task automatic idle_gap();
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    // Send one request and update the model on its transfer.
    task automatic send_req(logic cmd, logic [6:0] a, logic [6:0] b);
        idle_gap();
        req_valid       <= 1'b1;
        req_data.cmd    <= cmd;
        req_data.node_a <= a;
        req_data.node_b <= b;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        if (cmd == gkc_pkg::CMD_RUN)
            core_queue.insert(core_queue.size(), peel_core());
        else
        begin
            store_edge(a, b);
            loads_sent++;
        end
        @(negedge clk);
    endtask

    // Release the request channel and wait for every expected report.
    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (core_queue.size() != 0)
            @(negedge clk);
    endtask

    // Registers change only with the block idle; allow the clearing pass.
    task automatic write_cfg(logic idx, logic [6:0] val);
        drain();
        repeat (4 * NODES + 16) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == gkc_pkg::CFG_NODE_COUNT)
            cfg_nodes = val;
        else
            cfg_min_deg = val;
    endtask

    task automatic set_cfg(logic [6:0] nodes, logic [6:0] min_deg);
        if (nodes != cfg_nodes)
            write_cfg(gkc_pkg::CFG_NODE_COUNT, nodes);
        if (min_deg != cfg_min_deg)
            write_cfg(gkc_pkg::CFG_MIN_DEGREE, min_deg);
    endtask

    // Response side: random stall bursts, compare with the oldest report.
    initial
    begin
        gkc_pkg::rsp_t want;
        rsp_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (idle_enabled && $urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                reports_seen++;
                if (core_queue.size() == 0)
                begin
                    $error("core report with nothing expected: size %0d",
                           rsp_data.core_size);
                    error_count++;
                end
                else
                begin
                    want = core_queue.pop_front();
                    if (rsp_data.core_size !== want.core_size)
                    begin
                        $error("core_size expected %0d actual %0d",
                               want.core_size, rsp_data.core_size);
                        error_count++;
                    end
                    if (rsp_data.core_nonempty !== want.core_nonempty)
                    begin
                        $error("core_nonempty expected %0d actual %0d",
                               want.core_nonempty, rsp_data.core_nonempty);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("graph_k_core_size_tb: FAIL");
            $finish;
        end
    end

    // Stimulus.
    initial
    begin
        step_row_t     rows [ROW_COUNT];
        gkc_pkg::rsp_t got;
        int            n;
        int            runs;
        cycle_count  = 0;
        error_count  = 0;
        reports_seen = 0;
        loads_sent   = 0;
        idle_enabled = 1'b1;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_data     = '0;
        cfg_we       = 1'b0;
        cfg_index    = gkc_pkg::CFG_NODE_COUNT;
        cfg_data     = '0;
        cfg_nodes    = 7'd64;
        cfg_min_deg  = 7'd1;
        clear_graph();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: reset defaults, extremes, special cases.
        rows = '{
            '{7'd64, 7'd1, gkc_pkg::CMD_RUN,  7'd0,   7'd0,   1'b1, 7'd0},
            '{7'd64, 7'd0, gkc_pkg::CMD_RUN,  7'd127, 7'd127, 1'b1, 7'd64},
            '{7'd64, 7'd1, gkc_pkg::CMD_LOAD, 7'd1,   7'd64,  1'b0, 7'd0},
            '{7'd64, 7'd1, gkc_pkg::CMD_LOAD, 7'd64,  7'd1,   1'b0, 7'd0},
            '{7'd64, 7'd1, gkc_pkg::CMD_LOAD, 7'd5,   7'd5,   1'b0, 7'd0},
            '{7'd64, 7'd1, gkc_pkg::CMD_LOAD, 7'd0,   7'd3,   1'b0, 7'd0},
            '{7'd64, 7'd1, gkc_pkg::CMD_LOAD, 7'd3,   7'd65,  1'b0, 7'd0},
            '{7'd64, 7'd1, gkc_pkg::CMD_RUN,  7'd0,   7'd0,   1'b1, 7'd3},
            '{7'd127, 7'd2, gkc_pkg::CMD_LOAD, 7'd1,  7'd2,   1'b0, 7'd0},
            '{7'd127, 7'd2, gkc_pkg::CMD_LOAD, 7'd2,  7'd3,   1'b0, 7'd0},
            '{7'd127, 7'd2, gkc_pkg::CMD_LOAD, 7'd3,  7'd1,   1'b0, 7'd0},
            '{7'd127, 7'd2, gkc_pkg::CMD_LOAD, 7'd3,  7'd4,   1'b0, 7'd0},
            '{7'd127, 7'd2, gkc_pkg::CMD_RUN,  7'd0,  7'd0,   1'b1, 7'd3},
            '{7'd0,  7'd0, gkc_pkg::CMD_LOAD, 7'd1,   7'd1,   1'b0, 7'd0},
            '{7'd0,  7'd0, gkc_pkg::CMD_RUN,  7'd0,   7'd0,   1'b1, 7'd0},
            '{7'd1,  7'd1, gkc_pkg::CMD_LOAD, 7'd1,   7'd1,   1'b0, 7'd0},
            '{7'd1,  7'd1, gkc_pkg::CMD_RUN,  7'd0,   7'd0,   1'b1, 7'd1},
            '{7'd4,  7'd1, gkc_pkg::CMD_LOAD, 7'd1,   7'd2,   1'b0, 7'd0},
            '{7'd4,  7'd1, gkc_pkg::CMD_LOAD, 7'd3,   7'd4,   1'b0, 7'd0},
            '{7'd2,  7'd1, gkc_pkg::CMD_RUN,  7'd0,   7'd0,   1'b0, 7'd0},
            '{7'd64, 7'd64, gkc_pkg::CMD_RUN, 7'd0,   7'd0,   1'b1, 7'd0},
            '{7'd64, 7'd127, gkc_pkg::CMD_RUN, 7'd0,  7'd0,   1'b1, 7'd0}
        };
        foreach (rows[i])
        begin
            set_cfg(rows[i].nodes, rows[i].min_deg);
            send_req(rows[i].cmd, rows[i].a, rows[i].b);
            if (rows[i].known)
            begin
                got = core_queue[$];
                if (got.core_size !== rows[i].size)
                begin
                    $error("core_size table row %0d expected %0d model %0d",
                           i, rows[i].size, got.core_size);
                    error_count++;
                end
            end
        end

        // Random graphs: mostly small node counts, a few anywhere in 0..127.
        runs = 0;
        while (loads_sent + runs < 700)
        begin
            if ($urandom_range(0, 9) == 0)
                n = $urandom_range(0, 127);
            else
                n = $urandom_range(1, 12);
            set_cfg(7'(n), 7'($urandom_range(0, 5) == 0 ?
                    $urandom_range(0, 127) : $urandom_range(0, 4)));
            if (runs == 30)
                drain();
            if (loads_sent + runs > 600)
                idle_enabled = 1'b0;
            repeat ($urandom_range(0, 20))
            begin
                if ($urandom_range(0, 7) == 0)
                    send_req(gkc_pkg::CMD_LOAD, 7'($urandom), 7'($urandom));
                else
                    send_req(gkc_pkg::CMD_LOAD, 7'($urandom_range(1, n > 0 ? n : 1)),
                             7'($urandom_range(1, n > 0 ? n : 1)));
            end
            send_req(gkc_pkg::CMD_RUN, 7'($urandom), 7'($urandom));
            runs++;
        end

        drain();
        repeat (4 * NODES + 16) @(negedge clk);
        $display("Checked %0d core reports over %0d edge loads.", reports_seen, loads_sent);
        $display("Node counts 0..127 and minimum degrees 0..127 were exercised.");
        if (error_count == 0)
            $display("graph_k_core_size_tb: PASS");
        else
            $display("graph_k_core_size_tb: FAIL");
        $finish;
    end

endmodule
